/* hdl/cau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// opcode codes and shared constants of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int OP_WIDTH = 3;

   localparam logic [OP_WIDTH-1:0] OP_ADD = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_SUB = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_MUL = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_DIV = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_NEG = 3'd4;

   // result flags in rsp_tuser, lowest bit first
   localparam int FLAG_WIDTH = 2;

endpackage

/* hdl/cau_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_divider
// pipelined restoring divider, one quotient bit per stage, two lanes
// ----------------------------------------------------------------------------
module cau_divider #(
   parameter int W  = 16,
   parameter int F  = 8,
   parameter int SW = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [2*W+F-1:0]    num_re,
   input  logic [2*W+F-1:0]    num_im,
   input  logic [2*W-1:0]      den,
   input  logic [SW-1:0]       side_in,
   output logic                out_valid,
   output logic [W-1:0]        q_re,
   output logic [W-1:0]        q_im,
   output logic                ovf_re,
   output logic                ovf_im,
   output logic [SW-1:0]       side_out
);

   localparam int CW = 3 * W + F;

   logic [CW-1:0] rre_ff [W+1];
   logic [CW-1:0] rim_ff [W+1];
   logic [CW-1:0] den_ff [W+1];
   logic [W-1:0]  qre_ff [W+1];
   logic [W-1:0]  qim_ff [W+1];
   logic          ore_ff [W+1];
   logic          oim_ff [W+1];
   logic [SW-1:0] side_ff [W+1];
   logic          vld_ff [W+1];

   logic [CW-1:0] nre_ext;
   logic [CW-1:0] nim_ext;
   logic [CW-1:0] den_ext;

   assign nre_ext = CW'(num_re);
   assign nim_ext = CW'(num_im);
   assign den_ext = CW'(den);

   // first stage: a quotient of more than W bits means overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rre_ff[0]  <= nre_ext;
         rim_ff[0]  <= nim_ext;
         den_ff[0]  <= den_ext;
         qre_ff[0]  <= '0;
         qim_ff[0]  <= '0;
         ore_ff[0]  <= nre_ext >= (den_ext << W);
         oim_ff[0]  <= nim_ext >= (den_ext << W);
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 1; k <= W; k++) begin : g_stage
      localparam int BIT = W - k;
      logic [CW-1:0] trial;
      logic [CW-1:0] rre_in;
      logic [CW-1:0] rim_in;
      logic [W-1:0]  qre_in;
      logic [W-1:0]  qim_in;

      always_comb begin
         trial  = den_ff[k-1] << BIT;
         rre_in = rre_ff[k-1];
         rim_in = rim_ff[k-1];
         qre_in = qre_ff[k-1];
         qim_in = qim_ff[k-1];
         if (rre_ff[k-1] >= trial) begin
            rre_in      = rre_ff[k-1] - trial;
            qre_in[BIT] = 1'b1;
         end
         if (rim_ff[k-1] >= trial) begin
            rim_in      = rim_ff[k-1] - trial;
            qim_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rre_ff[k]  <= rre_in;
            rim_ff[k]  <= rim_in;
            den_ff[k]  <= den_ff[k-1];
            qre_ff[k]  <= qre_in;
            qim_ff[k]  <= qim_in;
            ore_ff[k]  <= ore_ff[k-1];
            oim_ff[k]  <= oim_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[W];
   assign q_re      = qre_ff[W];
   assign q_im      = qim_ff[W];
   assign ovf_re    = ore_ff[W];
   assign ovf_im    = oim_ff[W];
   assign side_out  = side_ff[W];

endmodule

/* hdl/complex_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// pipelined add, subtract, multiply, divide and negate on complex fixed point
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one item per operation: the opcode in req_tuser and
//   the operands a and b in req_tdata. rsp channel returns one result item
//   per request, in order: both result parts in rsp_tdata, the divide by
//   zero and saturation flags in rsp_tuser.
//   the pipeline runs through the input register, products, sums,
//   magnitude, then the divider with one quotient bit per stage plus its
//   overflow check, then the clamp and output register. every opcode walks
//   the same depth, so results stay in order. throughput is one item per
//   cycle while the receiver does not stall; the divider pipeline sets the
//   depth, the multipliers sit in their own stage.
//   reset clears all valid bits; the pipeline comes up empty and ready.
//   when the receiver stalls with a result waiting, the whole pipeline
//   holds, req_tready drops, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // a_re, a_im, b_re, b_im from the lowest bit up, zero padded to bytes
   input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   // action
   input  logic [cau_pkg::OP_WIDTH-1:0]          req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // res_re, res_im from the lowest bit up, zero padded to bytes
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   // div_by_zero, saturated
   output logic [cau_pkg::FLAG_WIDTH-1:0]        rsp_tuser
);

   localparam int W   = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int PW  = 2 * W;          // product width
   localparam int LW  = 2 * W + 1;      // width of sums of products
   localparam int NW  = 2 * W + F;      // scaled numerator width
   localparam int OW  = cau_pkg::OP_WIDTH;
   localparam int SW  = 3 + OW + 2 * LW; // divider sideband
   localparam int ODW = ((2 * W + 7) / 8) * 8;

   localparam logic signed [LW-1:0] POS_L = {{(LW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [LW-1:0] NEG_L = {{(LW-W+1){1'b1}}, {(W-1){1'b0}}};
   localparam logic [W-1:0] POS_Q = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] NEG_Q = {1'b1, {(W-1){1'b0}}};

   // global advance: the pipeline moves unless a result sits unclaimed
   logic en;
   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // stage 1: input register
   logic                 v1_ff;
   logic [OW-1:0]        op1_ff;
   logic signed [W-1:0]  ar1_ff, ai1_ff, br1_ff, bi1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff <= req_tuser;
         ar1_ff <= req_tdata[W-1:0];
         ai1_ff <= req_tdata[2*W-1:W];
         br1_ff <= req_tdata[3*W-1:2*W];
         bi1_ff <= req_tdata[4*W-1:3*W];
      end
   end

   // stage 2: the six products and the linear results
   logic                 v2_ff;
   logic [OW-1:0]        op2_ff;
   logic signed [PW-1:0] prr_ff, pii_ff, pri_ff, pir_ff, pbr_ff, pbi_ff;
   logic signed [LW-1:0] lre_ff, lim_ff;
   logic signed [LW-1:0] lre_in, lim_in;

   always_comb begin
      case (op1_ff)
         cau_pkg::OP_ADD: begin
            lre_in = LW'(ar1_ff) + LW'(br1_ff);
            lim_in = LW'(ai1_ff) + LW'(bi1_ff);
         end
         cau_pkg::OP_SUB: begin
            lre_in = LW'(ar1_ff) - LW'(br1_ff);
            lim_in = LW'(ai1_ff) - LW'(bi1_ff);
         end
         default: begin
            // negate of a, and a don't care for the others
            lre_in = -LW'(ar1_ff);
            lim_in = -LW'(ai1_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op2_ff <= op1_ff;
         prr_ff <= PW'(ar1_ff) * PW'(br1_ff);
         pii_ff <= PW'(ai1_ff) * PW'(bi1_ff);
         pri_ff <= PW'(ar1_ff) * PW'(bi1_ff);
         pir_ff <= PW'(ai1_ff) * PW'(br1_ff);
         pbr_ff <= PW'(br1_ff) * PW'(br1_ff);
         pbi_ff <= PW'(bi1_ff) * PW'(bi1_ff);
         lre_ff <= lre_in;
         lim_ff <= lim_in;
      end
   end

   // stage 3: sums of products; divide numerators or final values
   logic                 v3_ff;
   logic [OW-1:0]        op3_ff;
   logic signed [LW-1:0] val_re3_ff, val_im3_ff;
   logic [PW-1:0]        den3_ff;
   logic signed [LW-1:0] val_re_in, val_im_in;
   logic signed [LW-1:0] mre_full, mim_full;

   always_comb begin
      mre_full = LW'(prr_ff) - LW'(pii_ff);
      mim_full = LW'(pri_ff) + LW'(pir_ff);
      case (op2_ff)
         cau_pkg::OP_MUL: begin
            // arithmetic shift rounds toward minus infinity
            val_re_in = mre_full >>> F;
            val_im_in = mim_full >>> F;
         end
         cau_pkg::OP_DIV: begin
            // a times conj(b)
            val_re_in = LW'(prr_ff) + LW'(pii_ff);
            val_im_in = LW'(pir_ff) - LW'(pri_ff);
         end
         default: begin
            val_re_in = lre_ff;
            val_im_in = lim_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op3_ff     <= op2_ff;
         val_re3_ff <= val_re_in;
         val_im3_ff <= val_im_in;
         den3_ff    <= PW'(pbr_ff) + PW'(pbi_ff);
      end
   end

   // stage 4: sign and magnitude of the numerators, zero divisor check
   logic                 v4_ff;
   logic [OW-1:0]        op4_ff;
   logic signed [LW-1:0] val_re4_ff, val_im4_ff;
   logic [PW-1:0]        den4_ff;
   logic [PW-1:0]        mre4_ff, mim4_ff;
   logic                 nre4_ff, nim4_ff, dz4_ff;
   logic [LW-1:0]        abs_re, abs_im;

   assign abs_re = val_re3_ff[LW-1] ? (~val_re3_ff + 1'b1) : val_re3_ff;
   assign abs_im = val_im3_ff[LW-1] ? (~val_im3_ff + 1'b1) : val_im3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op4_ff     <= op3_ff;
         val_re4_ff <= val_re3_ff;
         val_im4_ff <= val_im3_ff;
         den4_ff    <= den3_ff;
         mre4_ff    <= abs_re[PW-1:0];
         mim4_ff    <= abs_im[PW-1:0];
         nre4_ff    <= val_re3_ff[LW-1];
         nim4_ff    <= val_im3_ff[LW-1];
         dz4_ff     <= (op3_ff == cau_pkg::OP_DIV) && (den3_ff == '0);
      end
   end

   // divider stages, with the other results riding along as sideband
   logic          dv_valid;
   logic [W-1:0]  q_re, q_im;
   logic          ovf_re, ovf_im;
   logic [SW-1:0] side_out;

   cau_divider #(
      .W  (W),
      .F  (F),
      .SW (SW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .num_re    (NW'(mre4_ff) << F),
      .num_im    (NW'(mim4_ff) << F),
      .den       (den4_ff),
      .side_in   ({dz4_ff, nre4_ff, nim4_ff, op4_ff, val_re4_ff, val_im4_ff}),
      .out_valid (dv_valid),
      .q_re      (q_re),
      .q_im      (q_im),
      .ovf_re    (ovf_re),
      .ovf_im    (ovf_im),
      .side_out  (side_out)
   );

   logic                 dz_d, nre_d, nim_d;
   logic [OW-1:0]        op_d;
   logic signed [LW-1:0] vre_d, vim_d;

   assign {dz_d, nre_d, nim_d, op_d, vre_d, vim_d} = side_out;

   // final stage: clamp to the signed range and register the result
   logic [W-1:0] res_re_in, res_im_in;
   logic         dz_in, sat_in;
   logic [W-1:0] res_re_ff, res_im_ff;
   logic         dz_ff, sat_ff;

   always_comb begin
      res_re_in = '0;
      res_im_in = '0;
      dz_in     = 1'b0;
      sat_in    = 1'b0;
      case (op_d) inside
         cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL, cau_pkg::OP_NEG: begin
            if (vre_d > POS_L) begin
               res_re_in = POS_Q;
               sat_in    = 1'b1;
            end else if (vre_d < NEG_L) begin
               res_re_in = NEG_Q;
               sat_in    = 1'b1;
            end else begin
               res_re_in = vre_d[W-1:0];
            end
            if (vim_d > POS_L) begin
               res_im_in = POS_Q;
               sat_in    = 1'b1;
            end else if (vim_d < NEG_L) begin
               res_im_in = NEG_Q;
               sat_in    = 1'b1;
            end else begin
               res_im_in = vim_d[W-1:0];
            end
         end
         cau_pkg::OP_DIV: begin
            if (dz_d) begin
               dz_in = 1'b1;
            end else begin
               // real part, by sign of the numerator
               if (!nre_d) begin
                  if (ovf_re || q_re > POS_Q) begin
                     res_re_in = POS_Q;
                     sat_in    = 1'b1;
                  end else begin
                     res_re_in = q_re;
                  end
               end else if (ovf_re || q_re > NEG_Q) begin
                  res_re_in = NEG_Q;
                  sat_in    = 1'b1;
               end else begin
                  res_re_in = ~q_re + 1'b1;
               end
               // imaginary part
               if (!nim_d) begin
                  if (ovf_im || q_im > POS_Q) begin
                     res_im_in = POS_Q;
                     sat_in    = 1'b1;
                  end else begin
                     res_im_in = q_im;
                  end
               end else if (ovf_im || q_im > NEG_Q) begin
                  res_im_in = NEG_Q;
                  sat_in    = 1'b1;
               end else begin
                  res_im_in = ~q_im + 1'b1;
               end
            end
         end
         default: begin
            // unused opcodes give zero and no flags
            res_re_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         dz_ff     <= dz_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ODW'({res_im_ff, res_re_ff});
   assign rsp_tuser  = {sat_ff, dz_ff};

endmodule

/* hdl/cau_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// port level checks of the complex arithmetic unit
// ----------------------------------------------------------------------------
module cau_checker #(
   parameter int DATA_WIDTH = 16
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [((2*DATA_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   input logic [cau_pkg::FLAG_WIDTH-1:0]        rsp_tuser
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // pipeline comes up empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a zero divisor gives a zero result without saturation
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[2*DATA_WIDTH-1:0] == '0 && !rsp_tuser[1])
      else $error("divide by zero result not clean");

   // input side is only held off while a result waits
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
